// ===== hw/rtl/gdn_pkg.sv =====
`default_nettype none

package gdn_pkg;

    // field widths
    localparam int DAY_WIDTH  = 16;
    localparam int MONTH_W    = 16;
    localparam int YEAR_W     = 16;
    localparam int YEAR_OUT_W = 18;
    localparam int DOM_W      = 5;
    localparam int MON_W      = 4;
    localparam int YMOD_W     = 9;

    // day magnitude must hold 1 - day and the cycle length
    localparam int MAG_W = (DAY_WIDTH + 1 > 18) ? DAY_WIDTH + 1 : 18;

    // 400-year cycle
    localparam int CYCLE_DAYS  = 146097;
    localparam int CYCLE_YEARS = 400;

    // month fold: biased month is month - 1 + 12 * MONTH_BIAS_Q, always >= 0
    localparam int MB_W         = MONTH_W + 1;
    localparam int MONTH_BIAS_Q = 2731;
    localparam int MONTH_BIAS   = 12 * MONTH_BIAS_Q - 1;
    localparam int Q12_W        = 14;
    localparam int RECIP12      = 43691;
    localparam int RECIP12_SHIFT = 19;

    // year mod 400: biased year is year + YEAR_BIAS, with YEAR_BIAS a multiple of 400
    localparam int YB_W          = YEAR_W + 1;
    localparam int YEAR_BIAS     = 36000;
    localparam int Q400_W        = 8;
    localparam int RECIP400      = 83887;
    localparam int RECIP400_SHIFT = 25;

    localparam int PROD_W = 34;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DOM_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // one classified item on its way from front to back
    typedef struct packed {
        logic                         neg;
        logic [MAG_W-1:0]             mag;
        logic [MON_W-1:0]             mon;
        logic [YEAR_OUT_W-1:0]        year;
        logic [YMOD_W-1:0]            ymod;
    } gdn_item_t;

    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        logic century;
        century = (ymod inside {9'd100, 9'd200, 9'd300});
        return (ymod[1:0] == 2'b00) && !century;
    endfunction

    function automatic logic [DOM_W-1:0] days_in(input logic [MON_W-1:0] mon,
                                                 input logic leap);
        logic [DOM_W-1:0] d;
        d = MONTH_LEN[4'(mon - MON_JAN)];
        if (mon == MON_FEB && leap) begin
            d = d + 5'd1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gregorian_date_normalizer_top.sv =====
// channel   ports                                       dir  notes
// input     s_valid s_ready s_day_in s_month_in          in   one date per beat
//           s_year_in
// result    m_valid m_ready m_day_out m_month_out        out  one date per beat
//           m_year_out
//
// the front steps through accept, month fold, and year mod 400 with the push; the back
// loads, passes the 400-year skip (no 16-bit day is long enough to use it), walks month
// by month until the day fits its month, and writes the result register: the walk sets
// the pace, about |day| / 30.4 months per item
// aresetn is synchronous and clears the control state of all three parts
// a two-entry queue parts front and back, and the result register parts the back
// from m_ready, so the front keeps taking beats while a result waits, until the queue fills
`default_nettype none

module gregorian_date_normalizer_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [gdn_pkg::DAY_WIDTH-1:0]   s_day_in,
    input  logic signed [gdn_pkg::MONTH_W-1:0]     s_month_in,
    input  logic signed [gdn_pkg::YEAR_W-1:0]      s_year_in,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [gdn_pkg::DOM_W-1:0]              m_day_out,
    output logic [gdn_pkg::MON_W-1:0]              m_month_out,
    output logic signed [gdn_pkg::YEAR_OUT_W-1:0]  m_year_out
);
    import gdn_pkg::*;

    // front to queue
    logic       push_valid;
    logic       queue_full;
    gdn_item_t  push_item;

    // queue to back
    logic       pop;
    logic       queue_empty;
    gdn_item_t  pop_item;

    // front: month fold by reciprocal multiply, day sign split, year mod 400
    gdn_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_day_in   (s_day_in),
        .s_month_in (s_month_in),
        .s_year_in  (s_year_in),
        .push_valid (push_valid),
        .queue_full (queue_full),
        .push_item  (push_item)
    );

    // short queue of classified items
    gdn_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_valid  (push_valid),
        .queue_full  (queue_full),
        .push_item   (push_item),
        .pop         (pop),
        .queue_empty (queue_empty),
        .pop_item    (pop_item)
    );

    // back: cycle skip, then the month-by-month day walk, then result register
    gdn_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_day_out   (m_day_out),
        .m_month_out (m_month_out),
        .m_year_out  (m_year_out)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/gdn_front.sv =====
`default_nettype none

module gdn_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [gdn_pkg::DAY_WIDTH-1:0]  s_day_in,
    input  logic signed [gdn_pkg::MONTH_W-1:0]    s_month_in,
    input  logic signed [gdn_pkg::YEAR_W-1:0]     s_year_in,
    output logic                                  push_valid,
    input  logic                                  queue_full,
    output gdn_pkg::gdn_item_t                    push_item
);
    import gdn_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_FOLD, F_MOD} fstate_t;

    fstate_t                  state_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [MB_W-1:0]          mon_biased_reg;
    logic [YEAR_W-1:0]        year_in_reg;
    logic [PROD_W-1:0]        prod12_reg;
    logic [MON_W-1:0]         mon_reg;
    logic [YB_W-1:0]          year0_reg;
    logic [YB_W-1:0]          ybias_reg;
    logic [PROD_W-1:0]        prod400_reg;

    logic [MAG_W-1:0]         day_ext;
    logic                     neg_next;
    logic [MAG_W-1:0]         mag_next;
    logic [MB_W-1:0]          mon_biased_next;
    logic [Q12_W-1:0]         q12;
    logic [MB_W-1:0]          mm_full;
    logic [Q12_W-1:0]         carry;
    logic [YB_W-1:0]          year0_next;
    logic [YB_W-1:0]          ybias_next;
    logic [Q400_W-1:0]        q400;
    logic [YB_W-1:0]          ymod_full;

    // accept: classify the day, start the divide-by-12 of the month
    always_comb begin
        day_ext         = {{(MAG_W - DAY_WIDTH){s_day_in[DAY_WIDTH-1]}}, s_day_in};
        neg_next        = s_day_in[DAY_WIDTH-1] || (s_day_in == '0);
        mag_next        = neg_next ? (MAG_W'(1) - day_ext) : day_ext;
        mon_biased_next = {s_month_in[MONTH_W-1], s_month_in} + MB_W'(MONTH_BIAS);
    end

    // fold: month into 1..12, carry into the year, start year mod 400
    always_comb begin
        q12        = prod12_reg[RECIP12_SHIFT +: Q12_W];
        mm_full    = mon_biased_reg - (MB_W'(q12) * MB_W'(12));
        carry      = q12 - Q12_W'(MONTH_BIAS_Q);
        year0_next = {year_in_reg[YEAR_W-1], year_in_reg}
                   + {{(YB_W - Q12_W){carry[Q12_W-1]}}, carry};
        ybias_next = year0_next + YB_W'(YEAR_BIAS);
    end

    always_comb begin
        q400      = prod400_reg[RECIP400_SHIFT +: Q400_W];
        ymod_full = ybias_reg - (YB_W'(q400) * YB_W'(CYCLE_YEARS));
    end

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_MOD);

    always_comb begin
        push_item.neg  = neg_reg;
        push_item.mag  = mag_reg;
        push_item.mon  = mon_reg;
        push_item.year = {{(YEAR_OUT_W - YB_W){year0_reg[YB_W-1]}}, year0_reg};
        push_item.ymod = ymod_full[YMOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        neg_reg        <= neg_next;
                        mag_reg        <= mag_next;
                        mon_biased_reg <= mon_biased_next;
                        year_in_reg    <= s_year_in;
                        prod12_reg     <= PROD_W'(mon_biased_next) * PROD_W'(RECIP12);
                        state_reg      <= F_FOLD;
                    end
                end
                F_FOLD: begin
                    mon_reg     <= mm_full[MON_W-1:0] + MON_JAN;
                    year0_reg   <= year0_next;
                    ybias_reg   <= ybias_next;
                    prod400_reg <= PROD_W'(ybias_next) * PROD_W'(RECIP400);
                    state_reg   <= F_MOD;
                end
                F_MOD: begin
                    if (!queue_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdn_queue.sv =====
`default_nettype none

module gdn_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                queue_full,
    input  gdn_pkg::gdn_item_t  push_item,
    input  logic                pop,
    output logic                queue_empty,
    output gdn_pkg::gdn_item_t  pop_item
);
    import gdn_pkg::*;

    gdn_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push;
    logic               do_pop;

    assign queue_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign queue_empty = (count_reg == '0);
    assign do_push     = push_valid && !queue_full;
    assign do_pop      = pop && !queue_empty;
    assign pop_item    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdn_back.sv =====
`default_nettype none

module gdn_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   queue_empty,
    input  gdn_pkg::gdn_item_t                     pop_item,
    output logic                                   pop,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [gdn_pkg::DOM_W-1:0]              m_day_out,
    output logic [gdn_pkg::MON_W-1:0]              m_month_out,
    output logic signed [gdn_pkg::YEAR_OUT_W-1:0]  m_year_out
);
    import gdn_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_SKIP, B_WALK, B_OUT} bstate_t;

    bstate_t                 state_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [MON_W-1:0]        mon_reg;
    logic [YEAR_OUT_W-1:0]   year_reg;
    logic [YMOD_W-1:0]       ymod_reg;
    logic [DOM_W-1:0]        day_reg;
    logic                    m_valid_reg;
    logic [DOM_W-1:0]        m_day_reg;
    logic [MON_W-1:0]        m_month_reg;
    logic [YEAR_OUT_W-1:0]   m_year_reg;

    logic [MON_W-1:0]        fwd_mon;
    logic [YEAR_OUT_W-1:0]   fwd_year;
    logic [YMOD_W-1:0]       fwd_ymod;
    logic [MON_W-1:0]        bwd_mon;
    logic [YEAR_OUT_W-1:0]   bwd_year;
    logic [YMOD_W-1:0]       bwd_ymod;
    logic [DOM_W-1:0]        dom;
    logic                    walk_more;
    logic [MAG_W-1:0]        mag_step;
    logic                    skip_more;
    logic [YEAR_OUT_W-1:0]   skip_year;
    logic [DOM_W-1:0]        day_back;
    logic                    out_free;

    always_comb begin
        // next month forward
        fwd_mon  = (mon_reg == MON_DEC) ? MON_JAN : mon_reg + 1'b1;
        fwd_year = (mon_reg == MON_DEC) ? year_reg + 1'b1 : year_reg;
        fwd_ymod = ymod_reg;
        if (mon_reg == MON_DEC) begin
            fwd_ymod = (ymod_reg == YMOD_W'(CYCLE_YEARS - 1)) ? '0 : ymod_reg + 1'b1;
        end
        // previous month backward
        bwd_mon  = (mon_reg == MON_JAN) ? MON_DEC : mon_reg - 1'b1;
        bwd_year = (mon_reg == MON_JAN) ? year_reg - 1'b1 : year_reg;
        bwd_ymod = ymod_reg;
        if (mon_reg == MON_JAN) begin
            bwd_ymod = (ymod_reg == '0) ? YMOD_W'(CYCLE_YEARS - 1) : ymod_reg - 1'b1;
        end
        // forward looks at the current month, backward at the one before
        dom       = neg_reg ? days_in(bwd_mon, is_leap(bwd_ymod))
                            : days_in(mon_reg, is_leap(ymod_reg));
        walk_more = (mag_reg > MAG_W'(dom));
        mag_step  = mag_reg - MAG_W'(dom);
        day_back  = dom - mag_reg[DOM_W-1:0] + 1'b1;
        skip_more = (mag_reg > MAG_W'(CYCLE_DAYS));
        skip_year = neg_reg ? year_reg - YEAR_OUT_W'(CYCLE_YEARS)
                            : year_reg + YEAR_OUT_W'(CYCLE_YEARS);
    end

    assign out_free    = !m_valid_reg || m_ready;
    assign pop         = (state_reg == B_IDLE) && !queue_empty;
    assign m_valid     = m_valid_reg;
    assign m_day_out   = m_day_reg;
    assign m_month_out = m_month_reg;
    assign m_year_out  = m_year_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // a new result in B_OUT takes over the slot of one leaving now
            if (m_valid_reg && m_ready && (state_reg != B_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!queue_empty) begin
                        neg_reg   <= pop_item.neg;
                        mag_reg   <= pop_item.mag;
                        mon_reg   <= pop_item.mon;
                        year_reg  <= pop_item.year;
                        ymod_reg  <= pop_item.ymod;
                        state_reg <= B_SKIP;
                    end
                end
                B_SKIP: begin
                    // whole 400-year cycles; year mod 400 is unchanged
                    if (skip_more) begin
                        mag_reg  <= mag_reg - MAG_W'(CYCLE_DAYS);
                        year_reg <= skip_year;
                    end else begin
                        state_reg <= B_WALK;
                    end
                end
                B_WALK: begin
                    if (neg_reg) begin
                        mon_reg  <= bwd_mon;
                        year_reg <= bwd_year;
                        ymod_reg <= bwd_ymod;
                        if (walk_more) begin
                            mag_reg <= mag_step;
                        end else begin
                            day_reg   <= day_back;
                            state_reg <= B_OUT;
                        end
                    end else begin
                        if (walk_more) begin
                            mag_reg  <= mag_step;
                            mon_reg  <= fwd_mon;
                            year_reg <= fwd_year;
                            ymod_reg <= fwd_ymod;
                        end else begin
                            day_reg   <= mag_reg[DOM_W-1:0];
                            state_reg <= B_OUT;
                        end
                    end
                end
                B_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_day_reg   <= day_reg;
                        m_month_reg <= mon_reg;
                        m_year_reg  <= year_reg;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gdn_checker.sv =====
`default_nettype none

module gdn_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic [gdn_pkg::DOM_W-1:0]              m_day_out,
    input logic [gdn_pkg::MON_W-1:0]              m_month_out,
    input logic signed [gdn_pkg::YEAR_OUT_W-1:0]  m_year_out
);
    import gdn_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_day_out)
            && $stable(m_month_out) && $stable(m_year_out))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_day_out != '0 && m_month_out >= MON_JAN && m_month_out <= MON_DEC)
        else $error("day or month out of range");

    a_short: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_month_out == 4'd4 || m_month_out == 4'd6
            || m_month_out == 4'd9 || m_month_out == 4'd11) |-> m_day_out <= 5'd30)
        else $error("day beyond a 30-day month");

    a_feb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_month_out == MON_FEB |-> m_day_out <= 5'd29)
        else $error("day beyond february");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind gregorian_date_normalizer_top gdn_checker u_gdn_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_day_out   (m_day_out),
    .m_month_out (m_month_out),
    .m_year_out  (m_year_out)
);

`default_nettype wire

// ===== tb/tb_gregorian_date_normalizer_top.sv =====
`timescale 1ns / 100ps

module tb_gregorian_date_normalizer_top;

    import gdn_pkg::*;

    // date arithmetic used by the predictor
    localparam longint DAYS_PER_ERA  = 146097;
    localparam longint YEARS_PER_ERA = 400;
    localparam int     DRAIN_CYCLES  = 1200;
    localparam int     MAX_REPORTS   = 10;

    localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // how the result side stalls
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_CHOPPY,
        READY_LONG
    } ready_mode_e;

    typedef struct {
        logic [DOM_W-1:0]      day;
        logic [MON_W-1:0]      mon;
        logic [YEAR_OUT_W-1:0] year;
    } date_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic signed [DAY_WIDTH-1:0]   s_day_in = '0;
    logic signed [MONTH_W-1:0]     s_month_in = '0;
    logic signed [YEAR_W-1:0]      s_year_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [DOM_W-1:0]              m_day_out;
    logic [MON_W-1:0]              m_month_out;
    logic signed [YEAR_OUT_W-1:0]  m_year_out;

    // expected dates, oldest first
    date_t pending_dates[$];

    int dates_sent = 0;
    int dates_checked = 0;
    int mismatches = 0;

    // sender burst control
    bit gaps_on = 1'b1;
    int burst_left = 0;
    int gap_max = 12;

    // receiver stall control
    ready_mode_e ready_mode = READY_ALWAYS;
    int stall_left = 0;

    gregorian_date_normalizer_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_day_in    (s_day_in),
        .s_month_in  (s_month_in),
        .s_year_in   (s_year_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_day_out   (m_day_out),
        .m_month_out (m_month_out),
        .m_year_out  (m_year_out)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // hard stop well past the slowest legal run (540 dates)
    initial begin
        #(40_000_000);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // modulo that always lands in 0..b-1, also for negative a
    function automatic longint floor_mod(input longint a, input longint b);
        longint r;
        r = a % b;
        return (r < 0) ? r + b : r;
    endfunction

    // month length, with february stretched in gregorian leap years
    function automatic longint month_days(input longint mon, input longint yr);
        longint d;
        bit leap;
        d = DAYS_IN_MONTH[mon - 1];
        leap = (floor_mod(yr, 400) == 0) ||
               (floor_mod(yr, 100) != 0 && floor_mod(yr, 4) == 0);
        if (mon == 2 && leap) begin
            d = d + 1;
        end
        return d;
    endfunction

    function automatic date_t normalize_date(input longint day, input longint month,
                                             input longint year);
        longint m0, mfold, mon, yr, left, k, dom;
        date_t r;
        // fold the month into 1..12, carrying whole years
        m0 = month - 1;
        mfold = floor_mod(m0, 12);
        yr = year + (m0 - mfold) / 12;
        mon = mfold + 1;
        if (day < 1) begin
            // walk backward through the preceding months
            left = 1 - day;
            if (left > DAYS_PER_ERA) begin
                k = (left - 1) / DAYS_PER_ERA;
                left -= k * DAYS_PER_ERA;
                yr -= k * YEARS_PER_ERA;
            end
            while (left > 0) begin
                mon -= 1;
                if (mon == 0) begin
                    mon = 12;
                    yr -= 1;
                end
                dom = month_days(mon, yr);
                if (left > dom) begin
                    left -= dom;
                end else begin
                    day = dom - left + 1;
                    left = 0;
                end
            end
        end else begin
            // walk forward until the day fits its month
            if (day > DAYS_PER_ERA) begin
                k = (day - 1) / DAYS_PER_ERA;
                day -= k * DAYS_PER_ERA;
                yr += k * YEARS_PER_ERA;
            end
            dom = month_days(mon, yr);
            while (day > dom) begin
                day -= dom;
                mon += 1;
                if (mon == 13) begin
                    mon = 1;
                    yr += 1;
                end
                dom = month_days(mon, yr);
            end
        end
        r.day  = DOM_W'(day);
        r.mon  = MON_W'(mon);
        r.year = YEAR_OUT_W'(yr);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: stall pattern and checker
    // ------------------------------------------------------------------

    // ready drops for a random stretch now and then; long mode holds it off longer
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (ready_mode == READY_ALWAYS) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= (ready_mode == READY_LONG) ? $urandom_range(0, 30)
                                                     : $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // every result beat is matched against the oldest pending date
    always @(posedge aclk) begin
        date_t exp_date;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result beat with no date pending: %0d-%0d-%0d",
                             $realtime, m_year_out, m_month_out, m_day_out);
                end
            end else begin
                exp_date = pending_dates.pop_front();
                dates_checked++;
                if (m_day_out !== exp_date.day || m_month_out !== exp_date.mon ||
                    m_year_out !== exp_date.year) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: date %0d mismatch: expected %0d-%0d-%0d got %0d-%0d-%0d",
                                 $realtime, dates_checked,
                                 $signed(exp_date.year), exp_date.mon, exp_date.day,
                                 m_year_out, m_month_out, m_day_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // present one date, hold it until accepted, then maybe pause between bursts
    task automatic send_date(input logic signed [DAY_WIDTH-1:0] day,
                             input logic signed [MONTH_W-1:0] month,
                             input logic signed [YEAR_W-1:0] year);
        s_valid    <= 1'b1;
        s_day_in   <= day;
        s_month_in <= month;
        s_year_in  <= year;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        pending_dates.push_back(normalize_date(longint'(day), longint'(month),
                                               longint'(year)));
        dates_sent++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // day mix: mostly short walks, some over years, a few across the whole field
    function automatic logic signed [DAY_WIDTH-1:0] pick_day();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return DAY_WIDTH'($urandom_range(0, 160)) - DAY_WIDTH'(80);
        end else if (sel < 9) begin
            return DAY_WIDTH'($urandom_range(0, 4000)) - DAY_WIDTH'(2000);
        end
        return DAY_WIDTH'($urandom);
    endfunction

    // months mostly in range, the rest small overflows or anything at all
    function automatic logic signed [MONTH_W-1:0] pick_month();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            return MONTH_W'($urandom_range(1, 12));
        end else if (sel < 9) begin
            return MONTH_W'($urandom_range(0, 60)) - MONTH_W'(30);
        end
        return MONTH_W'($urandom);
    endfunction

    // years near century boundaries often, so the leap exceptions come up
    function automatic logic signed [YEAR_W-1:0] pick_year();
        if ($urandom_range(0, 2) == 0) begin
            return YEAR_W'(100 * $urandom_range(0, 655)) - YEAR_W'(32700)
                   + YEAR_W'($urandom_range(0, 2)) - YEAR_W'(1);
        end
        return YEAR_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_field_extremes();
        send_date(16'sd1, 16'sd1, 16'sd2000);
        send_date(16'sd32767, 16'sd32767, 16'sd32767);
        send_date(-16'sd32768, -16'sd32768, -16'sd32768);
        send_date(-16'sd1, -16'sd1, -16'sd1);
        send_date(16'sd0, 16'sd0, 16'sd0);
        send_date(16'sd32767, 16'sd1, 16'sd0);
        send_date(-16'sd32768, 16'sd12, 16'sd0);
        // alternating bit patterns, both phases on every field
        send_date(16'sh5555, 16'shAAAA, 16'sh5555);
        send_date(16'shAAAA, 16'sh5555, 16'shAAAA);
    endtask

    // month below one borrows years, above twelve carries them
    task automatic test_month_fold();
        send_date(16'sd1, 16'sd0, 16'sd2000);
        send_date(16'sd1, -16'sd11, 16'sd2000);
        send_date(16'sd1, 16'sd13, 16'sd2000);
        send_date(16'sd15, 16'sd25, -16'sd5);
    endtask

    // day zero is the last day of the month before; negatives reach further back, days past the end run forward
    task automatic test_day_borrow();
        send_date(16'sd0, 16'sd1, 16'sd2000);
        send_date(16'sd0, 16'sd3, 16'sd2000);
        send_date(16'sd31, 16'sd4, 16'sd2021);
        send_date(16'sd366, 16'sd1, 16'sd2000);
        send_date(-16'sd365, 16'sd1, 16'sd2001);
    endtask

    // leap rule: every fourth year, not centuries unless divisible by 400
    task automatic test_leap_rule();
        send_date(16'sd29, 16'sd2, 16'sd2000);
        send_date(16'sd29, 16'sd2, 16'sd1900);
        send_date(16'sd29, 16'sd2, 16'sd2024);
        send_date(16'sd29, 16'sd2, 16'sd2023);
        send_date(16'sd29, 16'sd2, -16'sd100);
        send_date(16'sd29, 16'sd2, -16'sd400);
        send_date(16'sd29, 16'sd2, -16'sd4);
    endtask

    task automatic test_random_choppy(input int count);
        gaps_on = 1'b1;
        gap_max = 6;
        ready_mode = READY_CHOPPY;
        repeat (count) send_date(pick_day(), pick_month(), pick_year());
    endtask

    task automatic test_random_long_stalls(input int count);
        gaps_on = 1'b1;
        gap_max = 40;
        ready_mode = READY_LONG;
        repeat (count) send_date(pick_day(), pick_month(), pick_year());
    endtask

    // no idling on either side
    task automatic test_random_back_to_back(input int count);
        gaps_on = 1'b0;
        ready_mode = READY_ALWAYS;
        repeat (count) send_date(pick_day(), pick_month(), pick_year());
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_field_extremes();
        test_month_fold();
        test_day_borrow();
        test_leap_rule();
        test_random_choppy(200);
        test_random_long_stalls(150);
        test_random_back_to_back(165);

        // let the last beat go, then drain everything that is still pending
        s_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
        // any stray beat behind the last one would show up within a full walk
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d dates (field extremes, month fold, day borrow, leap rule,",
                 dates_sent);
        $display("random walks under bursts and stalls), %0d checked, %0d mismatches",
                 dates_checked, mismatches);
        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
